FILE: src/ukf_pkg.sv
package ukf_pkg;

	// Field widths
	localparam int unsigned KEY_W = 56;
	localparam int unsigned CNT_W = 8;
	localparam int unsigned CMD_W = 2;
	localparam int unsigned STS_W = 3;
	localparam int unsigned POS_W = 3;
	localparam int unsigned OCC_W = 4;

	// Default queue depth
	localparam int unsigned DEPTH_DEF = 8;

	// Command codes (code 3 behaves as a query)
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	// Status codes
	localparam logic [STS_W-1:0] STS_INSERTED  = 3'd0;
	localparam logic [STS_W-1:0] STS_FULL      = 3'd1;
	localparam logic [STS_W-1:0] STS_DUPLICATE = 3'd2;
	localparam logic [STS_W-1:0] STS_REMOVED   = 3'd3;
	localparam logic [STS_W-1:0] STS_NOTFOUND  = 3'd4;
	localparam logic [STS_W-1:0] STS_PRESENT   = 3'd5;
	localparam logic [STS_W-1:0] STS_ABSENT    = 3'd6;

	// One stored entry
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	// Result handed from the sequencer to the output register
	typedef struct packed {
		logic [OCC_W-1:0] occupancy;
		logic [CNT_W-1:0] move_count;
		logic [POS_W-1:0] position;
		logic [STS_W-1:0] status;
	} result_t;

	// Saturating counter increment
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (c == {CNT_W{1'b1}}) begin
			r = c;
		end else begin
			r = c + 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: src/ukf_mem.sv
module ukf_mem #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned AW    = 3
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  ukf_pkg::entry_t         wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output ukf_pkg::entry_t         rdata
);
	import ukf_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/ukf_seq.sv
module ukf_seq #(
	parameter int unsigned DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request side
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ukf_pkg::CMD_W-1:0]      in_cmd,
	input  logic [ukf_pkg::KEY_W-1:0]      in_key,
	// result side
	output logic                           res_valid,
	input  logic                           res_take,
	output ukf_pkg::result_t               res,
	// memory
	output logic                           mem_we,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_waddr,
	output ukf_pkg::entry_t                mem_wdata,
	output logic                           mem_re,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_raddr,
	input  ukf_pkg::entry_t                mem_rdata
);
	import ukf_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SEARCH = 4'b0010,
		S_MODIFY = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [CW-1:0]     held_q;
	logic [CW-1:0]     iss_q;
	logic              rv_s1;
	logic [AW-1:0]     ridx_s1;
	logic [AW-1:0]     pos_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STS_W-1:0]  status_q;

	logic              hit_now;
	logic              search_miss;
	logic [CW-1:0]     n_moves;
	logic [CW-1:0]     src_idx;
	logic              is_insert;
	logic              is_remove;

	assign is_insert   = (cmd_q == CMD_INSERT);
	assign is_remove   = (cmd_q == CMD_REMOVE);
	assign hit_now     = rv_s1 && (mem_rdata.key == key_q);
	assign search_miss = (iss_q == held_q) && !rv_s1;
	assign n_moves     = held_q - 1'b1;
	// entries ahead of the hole stay put, the rest move down by one
	assign src_idx     = (iss_q < CW'(pos_q)) ? iss_q : iss_q + 1'b1;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FINISH);
	assign res.status     = status_q;
	assign res.position   = POS_W'(pos_q);
	assign res.move_count = cnt_q;
	assign res.occupancy  = OCC_W'(held_q);

	// Memory port drive
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = iss_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = ridx_s1;
		mem_wdata.key = mem_rdata.key;
		mem_wdata.cnt = mem_rdata.cnt;
		unique case (state_q)
			S_SEARCH: begin
				mem_re = (iss_q < held_q) && !hit_now;
				if (!hit_now && search_miss && is_insert) begin
					mem_we        = 1'b1;
					mem_waddr     = held_q[AW-1:0];
					mem_wdata.key = key_q;
					mem_wdata.cnt = '0;
				end
			end
			S_MODIFY: begin
				mem_re    = (iss_q < n_moves);
				mem_raddr = src_idx[AW-1:0];
				mem_we    = rv_s1;
				if (ridx_s1 < pos_q) begin
					mem_wdata.cnt = sat_inc(mem_rdata.cnt);
				end
			end
			S_IDLE, S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q  <= '0;
			iss_q   <= '0;
			rv_s1   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						iss_q <= '0;
						rv_s1 <= 1'b0;
						if (in_cmd == CMD_INSERT && held_q == DEPTH_C) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (hit_now) begin
						rv_s1 <= 1'b0;
						iss_q <= '0;
						state_q <= is_remove ? S_MODIFY : S_FINISH;
					end else if (search_miss) begin
						if (is_insert) begin
							held_q <= held_q + 1'b1;
						end
						state_q <= S_FINISH;
					end else begin
						rv_s1 <= (iss_q < held_q);
						if (iss_q < held_q) begin
							iss_q <= iss_q + 1'b1;
						end
					end
				end
				S_MODIFY: begin
					rv_s1 <= (iss_q < n_moves);
					if (iss_q < n_moves) begin
						iss_q <= iss_q + 1'b1;
					end else if (!rv_s1) begin
						held_q  <= held_q - 1'b1;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_SEARCH || state_q == S_MODIFY) begin
			ridx_s1 <= (state_q == S_SEARCH) ? iss_q[AW-1:0] : iss_q[AW-1:0];
		end
		if (state_q == S_IDLE && in_valid) begin
			cmd_q    <= in_cmd;
			key_q    <= in_key;
			pos_q    <= '0;
			cnt_q    <= '0;
			status_q <= STS_FULL;
		end else if (state_q == S_SEARCH) begin
			if (hit_now) begin
				// a duplicate insert reports no position or counter
				if (cmd_q != CMD_INSERT) begin
					pos_q <= ridx_s1;
					cnt_q <= mem_rdata.cnt;
				end
				case (cmd_q)
					CMD_INSERT: status_q <= STS_DUPLICATE;
					CMD_REMOVE: status_q <= STS_REMOVED;
					default:    status_q <= STS_PRESENT;
				endcase
			end else if (search_miss) begin
				case (cmd_q)
					CMD_INSERT: status_q <= STS_INSERTED;
					CMD_REMOVE: status_q <= STS_NOTFOUND;
					default:    status_q <= STS_ABSENT;
				endcase
			end
		end
	end

endmodule

FILE: src/unique_key_fifo_with_remove_unit.sv
// Ordered queue of unique 56-bit keys with per-entry saturating move counters.
// Input stream (s_*): one request per beat; s_tuser carries the command
// (insert, remove, query), s_tdata the key. Output stream (m_*): one result
// per request; m_tuser carries the status, m_tdata position, move count
// and occupancy after the command.
// Entries live in a single memory with a registered read. A
// request first scans the entries front to back, one read per cycle; a
// remove then compacts the queue, re-reading and writing one entry a cycle
// and bumping the counters of entries ahead of the removed one.
// An insert when full is answered without a scan; a query miss or a new-key
// insert scans all entries held; a hit (query, remove or duplicate insert)
// ends the scan at its entry, and a remove then adds the compaction.
// One request is in flight at a time; a new request is taken as soon as
// the previous one has been turned into a result.
// Results sit in an output register: a stalled receiver holds it, and the
// block still accepts and works on the next request meanwhile.
// Reset empties the queue; memory contents need no clearing.
module unique_key_fifo_with_remove_unit #(
	parameter int unsigned DEPTH = ukf_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // key[55:0]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // position[2:0], move_count[10:3], occupancy[14:11], zero
	output logic [2:0]  m_tuser    // status[2:0]
);
	import ukf_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	logic          res_valid;
	logic          res_take;
	result_t       res;
	result_t       out_q;
	logic          out_valid_q;

	ukf_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ukf_seq #(
		.DEPTH (DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_key    (s_tdata),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Output register: loads when empty or being drained
	assign res_take = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {1'b0, out_q.occupancy, out_q.move_count, out_q.position};

endmodule

FILE: src/ukf_checker.sv
module ukf_checker #(
	parameter int unsigned DEPTH = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [2:0]  m_tuser
);
	import ukf_pkg::*;

	logic no_match;
	logic in_fire;

	assign no_match = (m_tuser == STS_INSERTED) || (m_tuser == STS_FULL) ||
		(m_tuser == STS_DUPLICATE) || (m_tuser == STS_NOTFOUND) || (m_tuser == STS_ABSENT);
	assign in_fire = s_tvalid && s_tready && (s_tdata != '1 || s_tuser != '1);

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Position and counter are zero without a matched entry
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && no_match |-> m_tdata[10:0] == 11'd0)
		else $error("nonzero position or count without a match");

	// Full is reported only at full occupancy
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STS_FULL |-> m_tdata[14:11] == OCC_W'(DEPTH))
		else $error("full status with wrong occupancy");

	// Status is always a defined code; padding bit stays zero
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 3'd7 && !m_tdata[15])
		else $error("undefined status or padding set");

	// A request is never accepted in the cycle after one was accepted
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire || (s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while busy");

endmodule

bind unique_key_fifo_with_remove_unit ukf_checker #(.DEPTH(DEPTH)) u_ukf_checker (.*);
